/* sv/assert_macros.svh */
// assertion macros shared by the cache directory modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* sv/lfatc_pkg.sv */
// types and constants of the fully associative tag cache directory
package lfatc_pkg;

   localparam int ENTRIES = 8;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int KEY_W   = 64;
   localparam int STAMP_W = 32;
   localparam int SLOT_W  = 3;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic update;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rd_last;
   } dp_status_type;

endpackage

/* sv/lru_fully_associative_tag_cache_core.sv */
// top level of the fully associative tag cache directory with lru replacement
//
// Fully associative directory of ENTRIES keys (64-bit) with least-recently-used
// replacement by 32-bit use stamps; one response beat per request beat. Each
// request passes an accept state, a scan that reads one entry per cycle from
// the key and stamp memories through their single registered read port, a
// wait state for the last compare and the directory update that loads the
// response register; the next request is taken only after that update. A
// waiting response does not block the next request; the update of the
// following one holds while the response register is full and stalled.
// Valid bits sit in flip-flops cleared by reset, so no clearing pass is needed.
// A lookup hit and every insert take a fresh stamp from one counter that wraps.

module lru_fully_associative_tag_cache_core import lfatc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic [KEY_W-1:0]    req_key,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_hit,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic                rsp_evicted
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   lfatc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lfatc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_opcode  (req_opcode),
      .req_key     (req_key),
      .rsp_hit     (rsp_hit),
      .rsp_slot    (rsp_slot),
      .rsp_evicted (rsp_evicted)
   );

endmodule

/* sv/lfatc_ctrl.sv */
// sequencer for request accept, entry scan, directory update and response hand-off
`include "assert_macros.svh"

module lfatc_ctrl import lfatc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      rsp_free   = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.rd_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            // last entry is compared in this cycle
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold the update until the output register can take the beat
            if (rsp_free) begin
               cmd.update   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_valid && !req_stall, state_ff == ST_SCAN)
   `ASSERT_NEXT(a_scan_end_waits, clock, reset, state_ff == ST_SCAN && status.rd_last,
                state_ff == ST_WAIT)
   `ASSERT_NEXT(a_update_loads_rsp, clock, reset, cmd.update,
                rsp_valid_ff && state_ff == ST_IDLE)

endmodule

/* sv/lfatc_dp.sv */
// directory storage, scan compare stage, use counter and response register
`include "assert_macros.svh"

module lfatc_dp import lfatc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status,
   input  logic                req_opcode,
   input  logic [KEY_W-1:0]    req_key,
   output logic                rsp_hit,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic                rsp_evicted
);

   // storage
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [KEY_W-1:0]    key_mem   [ENTRIES];
   logic [STAMP_W-1:0]  stamp_mem [ENTRIES];
   logic [STAMP_W-1:0]  use_ctr_ff, use_ctr_in, ctr_next;

   // request latch
   op_type              op_ff;
   logic [KEY_W-1:0]    key_ff;

   // scan read stage
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                cmp_vld_ff;
   logic [IDX_W-1:0]    cmp_idx_ff;
   logic                vld_rd_ff;
   logic [KEY_W-1:0]    key_rd_ff;
   logic [STAMP_W-1:0]  stamp_rd_ff;

   // scan accumulators
   logic                match_found_ff, match_found_in;
   logic [IDX_W-1:0]    match_idx_ff, match_idx_in;
   logic                free_found_ff, free_found_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic [STAMP_W-1:0]  min_stamp_ff, min_stamp_in;
   logic [IDX_W-1:0]    min_idx_ff, min_idx_in;

   // update
   logic                is_insert;
   logic [IDX_W-1:0]    fill_idx;
   logic [IDX_W-1:0]    stamp_idx;
   logic                stamp_we;

   // response register
   logic                rsp_hit_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic                rsp_evicted_ff;

   assign is_insert = (op_ff == OP_INSERT);
   assign fill_idx  = free_found_ff ? free_idx_ff : min_idx_ff;
   assign stamp_idx = is_insert ? fill_idx : match_idx_ff;
   assign stamp_we  = cmd.update && (is_insert || match_found_ff);
   assign ctr_next  = STAMP_W'(use_ctr_ff + STAMP_W'(1));

   assign status.rd_last = (rd_idx_ff == IDX_W'(ENTRIES - 1));

   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (cmd.start) begin
         rd_idx_in = '0;
      end else if (cmd.scan) begin
         rd_idx_in = IDX_W'(rd_idx_ff + IDX_W'(1));
      end
   end

   always_comb begin
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      min_stamp_in   = min_stamp_ff;
      min_idx_in     = min_idx_ff;
      if (cmd.start) begin
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
      end else if (cmp_vld_ff) begin
         if (vld_rd_ff && key_rd_ff == key_ff && !match_found_ff) begin
            match_found_in = 1'b1;
            match_idx_in   = cmp_idx_ff;
         end
         if (!vld_rd_ff && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = cmp_idx_ff;
         end
         // strict less-than keeps the lowest index on ties
         if (cmp_idx_ff == '0 || stamp_rd_ff < min_stamp_ff) begin
            min_stamp_in = stamp_rd_ff;
            min_idx_in   = cmp_idx_ff;
         end
      end
   end

   always_comb begin
      valid_in   = valid_ff;
      use_ctr_in = use_ctr_ff;
      if (cmd.update && is_insert) begin
         valid_in[fill_idx] = 1'b1;
      end
      if (stamp_we) begin
         use_ctr_in = ctr_next;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         use_ctr_ff <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         use_ctr_ff <= use_ctr_in;
         cmp_vld_ff <= cmd.scan;
      end
   end

   // payload and scan registers
   always_ff @(posedge clock) begin
      rd_idx_ff      <= rd_idx_in;
      cmp_idx_ff     <= rd_idx_ff;
      vld_rd_ff      <= valid_ff[rd_idx_ff];
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      min_stamp_ff   <= min_stamp_in;
      min_idx_ff     <= min_idx_in;
      if (cmd.start) begin
         op_ff  <= op_type'(req_opcode);
         key_ff <= req_key;
      end
      if (cmd.update) begin
         rsp_hit_ff     <= !is_insert && match_found_ff;
         rsp_evicted_ff <= is_insert && !free_found_ff;
         if (is_insert) begin
            rsp_slot_ff <= SLOT_W'(fill_idx);
         end else if (match_found_ff) begin
            rsp_slot_ff <= SLOT_W'(match_idx_ff);
         end else begin
            rsp_slot_ff <= '0;
         end
      end
   end

   // key and stamp memories, one registered read port each
   always_ff @(posedge clock) begin
      key_rd_ff   <= key_mem[rd_idx_ff];
      stamp_rd_ff <= stamp_mem[rd_idx_ff];
      if (cmd.update && is_insert) begin
         key_mem[fill_idx] <= key_ff;
      end
      if (stamp_we) begin
         stamp_mem[stamp_idx] <= ctr_next;
      end
   end

   assign rsp_hit     = rsp_hit_ff;
   assign rsp_slot    = rsp_slot_ff;
   assign rsp_evicted = rsp_evicted_ff;

   `ASSERT_NEXT(a_fill_sets_valid, clock, reset, cmd.update && is_insert,
                valid_ff[$past(fill_idx)])
   `ASSERT_NEXT(a_stamp_advances_ctr, clock, reset, stamp_we,
                use_ctr_ff == STAMP_W'($past(use_ctr_ff) + STAMP_W'(1)))
   `ASSERT_IMPL(a_evict_only_when_full, clock, reset,
                cmd.update && is_insert && !free_found_ff, &valid_ff)

endmodule
